// ===== rtl/grdd_pkg.sv =====
package grdd_pkg;

   localparam int unsigned AXES       = 3;
   localparam int unsigned RAW_W      = 16;
   localparam int unsigned SUM_W      = 17;
   localparam int unsigned MDPS_W     = 23;
   localparam int unsigned FS_W       = 2;
   localparam int unsigned QUART_W    = 9;
   localparam int unsigned PROD_W     = SUM_W + QUART_W;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic signed [RAW_W-1:0]  raw_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [MDPS_W-1:0] mdps_type;
   typedef logic        [RAW_W-1:0]  thr_type;
   typedef logic        [FS_W-1:0]   fs_type;
   typedef logic        [QUART_W-1:0] quart_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FULL_SCALE = 3'd0,
      CSR_OFFSET_X   = 3'd1,
      CSR_OFFSET_Y   = 3'd2,
      CSR_OFFSET_Z   = 3'd3,
      CSR_DEADBAND_X = 3'd4,
      CSR_DEADBAND_Y = 3'd5,
      CSR_DEADBAND_Z = 3'd6
   } csr_index_type;

   typedef enum logic [FS_W-1:0] {
      FS_250DPS  = 2'd0,
      FS_500DPS  = 2'd1,
      FS_2000DPS = 2'd2
   } fs_sel_type;

   localparam quart_type QUART_250  = 9'd35;
   localparam quart_type QUART_500  = 9'd70;
   localparam quart_type QUART_2000 = 9'd280;

   // Sensitivity in quarter mdps per digit. The reserved code acts as 250 dps.
   function automatic quart_type quarters(input fs_type fs);
      quart_type q;
      unique case (fs)
         FS_500DPS:  q = QUART_500;
         FS_2000DPS: q = QUART_2000;
         default:    q = QUART_250;
      endcase
      return q;
   endfunction

   // Saturate a 17-bit signed value to the signed 16-bit range.
   function automatic raw_type sat_to_raw(input sum_type v);
      raw_type r;
      if (v[SUM_W-1] != v[SUM_W-2]) begin
         r = v[SUM_W-1] ? {1'b1, {(RAW_W-1){1'b0}}} : {1'b0, {(RAW_W-1){1'b1}}};
      end else begin
         r = v[RAW_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/grdd_front.sv =====
module grdd_front #(
   parameter int unsigned DEC_LOG2 = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  grdd_pkg::raw_type raw [grdd_pkg::AXES],
   input  grdd_pkg::raw_type offset [grdd_pkg::AXES],
   output logic              out_valid,
   input  logic              out_ready,
   output grdd_pkg::raw_type quot [grdd_pkg::AXES]
);

   localparam grdd_pkg::sum_type BIAS = grdd_pkg::SUM_W'((2 ** DEC_LOG2) - 1);

   grdd_pkg::sum_type diff    [grdd_pkg::AXES];
   grdd_pkg::raw_type sat_d   [grdd_pkg::AXES];
   grdd_pkg::sum_type biased  [grdd_pkg::AXES];
   grdd_pkg::raw_type quot_in [grdd_pkg::AXES];
   grdd_pkg::raw_type quot_ff [grdd_pkg::AXES];
   logic              valid_ff;

   // Division toward zero: negative values get 2^n - 1 added before the
   // arithmetic shift.
   always_comb begin
      for (int a = 0; a < grdd_pkg::AXES; a++) begin
         diff[a]    = grdd_pkg::SUM_W'(raw[a]) - grdd_pkg::SUM_W'(offset[a]);
         sat_d[a]   = grdd_pkg::sat_to_raw(diff[a]);
         biased[a]  = grdd_pkg::SUM_W'(sat_d[a]) + (sat_d[a][grdd_pkg::RAW_W-1] ? BIAS : '0);
         quot_in[a] = grdd_pkg::RAW_W'(biased[a] >>> DEC_LOG2);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign quot      = quot_ff;

endmodule

// ===== rtl/grdd_accum.sv =====
module grdd_accum #(
   parameter int unsigned DEC_LOG2 = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  grdd_pkg::raw_type quot [grdd_pkg::AXES],
   output logic              out_valid,
   input  logic              out_ready,
   output grdd_pkg::sum_type total [grdd_pkg::AXES]
);

   localparam int unsigned CNT_W = (DEC_LOG2 > 0) ? DEC_LOG2 : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((2 ** DEC_LOG2) - 1);

   grdd_pkg::sum_type sum_ff   [grdd_pkg::AXES];
   grdd_pkg::sum_type sum_in   [grdd_pkg::AXES];
   grdd_pkg::sum_type total_ff [grdd_pkg::AXES];
   logic [CNT_W-1:0]  count_ff;
   logic              valid_ff;
   logic              last;
   logic              take;

   always_comb begin
      for (int a = 0; a < grdd_pkg::AXES; a++) begin
         sum_in[a] = sum_ff[a] + grdd_pkg::SUM_W'(quot[a]);
      end
   end

   assign last     = (count_ff == CNT_LAST);
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         for (int a = 0; a < grdd_pkg::AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         if (take) begin
            valid_ff <= last;
            count_ff <= last ? '0 : count_ff + 1'b1;
            for (int a = 0; a < grdd_pkg::AXES; a++) begin
               sum_ff[a] <= last ? '0 : sum_in[a];
            end
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && last) begin
         total_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign total     = total_ff;

endmodule

// ===== rtl/grdd_post.sv =====
module grdd_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  grdd_pkg::sum_type  total [grdd_pkg::AXES],
   input  grdd_pkg::thr_type  thr [grdd_pkg::AXES],
   input  grdd_pkg::fs_type   full_scale,
   output logic               out_valid,
   input  logic               out_ready,
   output grdd_pkg::raw_type  counts [grdd_pkg::AXES],
   output grdd_pkg::mdps_type mdps [grdd_pkg::AXES]
);

   // Stage A: deadband and saturation.
   logic [grdd_pkg::SUM_W-1:0] sum_mag   [grdd_pkg::AXES];
   grdd_pkg::sum_type          kept      [grdd_pkg::AXES];
   grdd_pkg::raw_type          cnt_in    [grdd_pkg::AXES];
   grdd_pkg::raw_type          cnt_ff    [grdd_pkg::AXES];
   logic                       a_valid_ff;
   logic                       a_ready;

   // Stage B: scaling to mdps.
   logic [grdd_pkg::SUM_W-1:0]  cnt_mag  [grdd_pkg::AXES];
   logic [grdd_pkg::PROD_W-1:0] rounded  [grdd_pkg::AXES];
   grdd_pkg::mdps_type          mdps_in  [grdd_pkg::AXES];
   grdd_pkg::mdps_type          mdps_ff  [grdd_pkg::AXES];
   grdd_pkg::raw_type           cnt_o_ff [grdd_pkg::AXES];
   grdd_pkg::quart_type         quart;
   logic                        b_valid_ff;
   logic                        b_ready;

   always_comb begin
      for (int a = 0; a < grdd_pkg::AXES; a++) begin
         sum_mag[a] = total[a][grdd_pkg::SUM_W-1] ? -total[a] : total[a];
         kept[a]    = (sum_mag[a] >= grdd_pkg::SUM_W'(thr[a])) ? total[a] : '0;
         cnt_in[a]  = grdd_pkg::sat_to_raw(kept[a]);
      end
   end

   // Quarter units keep 8.75 and 17.5 exact; +2 then >>2 rounds half away
   // from zero on the magnitude.
   always_comb begin
      quart = grdd_pkg::quarters(full_scale);
      for (int a = 0; a < grdd_pkg::AXES; a++) begin
         cnt_mag[a] = cnt_ff[a][grdd_pkg::RAW_W-1] ? -grdd_pkg::SUM_W'(cnt_ff[a])
                                                   : grdd_pkg::SUM_W'(cnt_ff[a]);
         rounded[a] = grdd_pkg::PROD_W'(cnt_mag[a]) * grdd_pkg::PROD_W'(quart)
                    + grdd_pkg::PROD_W'(2);
         mdps_in[a] = cnt_ff[a][grdd_pkg::RAW_W-1]
                    ? -grdd_pkg::MDPS_W'(rounded[a] >> 2)
                    :  grdd_pkg::MDPS_W'(rounded[a] >> 2);
      end
   end

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         cnt_ff <= cnt_in;
      end
      if (a_valid_ff && b_ready) begin
         cnt_o_ff <= cnt_ff;
         mdps_ff  <= mdps_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign counts    = cnt_o_ff;
   assign mdps      = mdps_ff;

endmodule

// ===== rtl/gyro_rate_decimator_deadband_core.sv =====
// Three-axis gyro rate decimator with deadband.
// Each req beat carries one raw sample per axis. The zero-rate offset is
// subtracted with saturation, the difference is divided by 2^DECIMATION_LOG2
// toward zero and summed; every 2^DECIMATION_LOG2-th beat produces one rsp
// beat with the dead-banded counts and their value in mdps (8.75, 17.5 or
// 70 mdps per digit, rounded half away from zero).
// Configuration goes through csr_we/csr_addr/csr_wdata, one register per
// write, and should change only while the pipeline is empty.
// Throughput: one req beat per cycle unless rsp_tready stalls the output.
// The pipeline is five registers deep: input, offset/divide, accumulate,
// deadband, mdps scaling, and the rsp beat passes through each in turn.
// Reset clears the sums, the sample counter, all configuration registers and
// all valid flags. When rsp_tready is low the result holds in the output
// register and the stages behind it keep filling; req_tready drops only once
// every stage holds a beat.
module gyro_rate_decimator_deadband_core #(
   parameter int unsigned DECIMATION_LOG2 = 2
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: raw_x [15:0], raw_y [31:16], raw_z [47:32]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,
   // rsp_tdata: rate_x_counts [15:0], rate_y_counts [31:16],
   // rate_z_counts [47:32], rate_x_mdps [70:48], rate_y_mdps [93:71],
   // rate_z_mdps [116:94], zero [119:117]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [grdd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [grdd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   grdd_pkg::fs_type   full_scale_ff;
   grdd_pkg::raw_type  offset_ff [grdd_pkg::AXES];
   grdd_pkg::thr_type  thr_ff    [grdd_pkg::AXES];

   grdd_pkg::raw_type  raw_ff    [grdd_pkg::AXES];
   logic               in_valid_ff;

   logic               front_ready;
   logic               front_valid;
   grdd_pkg::raw_type  quot      [grdd_pkg::AXES];
   logic               accum_ready;
   logic               accum_valid;
   grdd_pkg::sum_type  total     [grdd_pkg::AXES];
   logic               post_ready;
   grdd_pkg::raw_type  counts    [grdd_pkg::AXES];
   grdd_pkg::mdps_type mdps      [grdd_pkg::AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= '0;
         for (int a = 0; a < grdd_pkg::AXES; a++) begin
            offset_ff[a] <= '0;
            thr_ff[a]    <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_addr)
            grdd_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata[grdd_pkg::FS_W-1:0];
            grdd_pkg::CSR_OFFSET_X:   offset_ff[0]  <= csr_wdata;
            grdd_pkg::CSR_OFFSET_Y:   offset_ff[1]  <= csr_wdata;
            grdd_pkg::CSR_OFFSET_Z:   offset_ff[2]  <= csr_wdata;
            grdd_pkg::CSR_DEADBAND_X: thr_ff[0]     <= csr_wdata;
            grdd_pkg::CSR_DEADBAND_Y: thr_ff[1]     <= csr_wdata;
            grdd_pkg::CSR_DEADBAND_Z: thr_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !in_valid_ff || front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         raw_ff[0] <= req_tdata[15:0];
         raw_ff[1] <= req_tdata[31:16];
         raw_ff[2] <= req_tdata[47:32];
      end
   end

   grdd_front #(
      .DEC_LOG2 (DECIMATION_LOG2)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (front_ready),
      .raw       (raw_ff),
      .offset    (offset_ff),
      .out_valid (front_valid),
      .out_ready (accum_ready),
      .quot      (quot)
   );

   grdd_accum #(
      .DEC_LOG2 (DECIMATION_LOG2)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (accum_ready),
      .quot      (quot),
      .out_valid (accum_valid),
      .out_ready (post_ready),
      .total     (total)
   );

   grdd_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accum_valid),
      .in_ready   (post_ready),
      .total      (total),
      .thr        (thr_ff),
      .full_scale (full_scale_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .counts     (counts),
      .mdps       (mdps)
   );

   assign rsp_tdata = {3'b000, mdps[2], mdps[1], mdps[0], counts[2], counts[1], counts[0]};

endmodule
